FILE: rtl/fblpack_pkg.sv
// ----------------------------------------------------------------------------
// fblpack_pkg
// Types and constants shared by the five-bit letter packer modules.
// ----------------------------------------------------------------------------
package fblpack_pkg;

   // Offset that maps 'a' to code zero
   localparam logic [7:0] CodeBase = 8'h61;

   // Default depth of the queue between front and back
   localparam int QueueDepth = 4;

   // One input beat
   typedef struct packed {
      logic [7:0] letter;
      logic       end_of_message;
   } req_type;

   // One output beat
   typedef struct packed {
      logic [7:0] packed_byte;
      logic       is_high_bits;
      logic       last_byte;
   } rsp_type;

   // Work for the back end: one or two output beats
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } job_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

FILE: rtl/fblpack_front.sv
// ----------------------------------------------------------------------------
// fblpack_front
// Accepts letters, tracks the group state and forms the output bytes that
// each letter causes, handing them to the queue as one job.
// ----------------------------------------------------------------------------
module fblpack_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  fblpack_pkg::req_type       req_data,
   output logic                       req_stall,
   input  fblpack_pkg::q_status_type  q_status,
   output logic                       push,
   output fblpack_pkg::job_type       push_job
);

   logic [3:0] held_ff, held_in;
   logic [7:0] acc_ff, acc_in;
   logic [2:0] pos_ff, pos_in;

   logic       accept;
   logic [7:0] diff;
   logic [4:0] code;
   logic [7:0] acc_new;
   logic       eom;

   // Stall while the queue has no room
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // Form the code and merge its fifth bit into the group byte
   assign diff    = req_data.letter - fblpack_pkg::CodeBase;
   assign code    = diff[4:0];
   assign acc_new = acc_ff | ({code[4], 7'b0} >> pos_ff);
   assign eom     = req_data.end_of_message;

   // Build the job and the next state
   always_comb begin
      held_in  = held_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      push     = 1'b0;
      push_job = '0;
      if (accept) begin
         pos_in = pos_ff + 3'd1;
         acc_in = acc_new;
         if (!pos_ff[0]) begin
            // even code: hold its nibble, flush at end of message
            held_in = code[3:0];
            if (eom) begin
               push                = 1'b1;
               push_job.two        = 1'b1;
               push_job.first      = '{packed_byte: {code[3:0], 4'h0},
                                       is_high_bits: 1'b0, last_byte: 1'b0};
               push_job.second     = '{packed_byte: acc_new,
                                       is_high_bits: 1'b1, last_byte: 1'b1};
            end
         end else begin
            // odd code: emit the pair byte, then the group byte if due
            held_in        = 4'h0;
            push           = 1'b1;
            push_job.first = '{packed_byte: {held_ff, code[3:0]},
                               is_high_bits: 1'b0, last_byte: 1'b0};
            if (pos_ff == 3'd7 || eom) begin
               push_job.two    = 1'b1;
               push_job.second = '{packed_byte: acc_new,
                                   is_high_bits: 1'b1, last_byte: eom};
            end
            if (pos_ff == 3'd7) begin
               acc_in = 8'h00;
            end
         end
         if (eom) begin
            held_in = 4'h0;
            acc_in  = 8'h00;
            pos_in  = 3'd0;
         end
      end
   end

   // Hold the group state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 4'h0;
         acc_ff  <= 8'h00;
         pos_ff  <= 3'd0;
      end else begin
         held_ff <= held_in;
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
      end
   end

   // A message end returns the group to its start
   a_eom_restart: assert property (@(posedge clock) disable iff (reset)
      accept && eom |=> pos_ff == 3'd0)
      else $error("group position not cleared after end of message");

   // No nibble is held at an even position
   a_held_clear: assert property (@(posedge clock) disable iff (reset)
      !pos_ff[0] |-> held_ff == 4'h0)
      else $error("nibble held at even group position");

   // Fifth bits only occupy positions already taken
   a_acc_bits: assert property (@(posedge clock) disable iff (reset)
      (acc_ff & (8'hff >> pos_ff)) == 8'h00)
      else $error("fifth-bit byte has bits beyond group position");

endmodule

FILE: rtl/fblpack_queue.sv
// ----------------------------------------------------------------------------
// fblpack_queue
// Short job queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module fblpack_queue #(
   parameter int Depth = fblpack_pkg::QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fblpack_pkg::job_type       push_job,
   input  logic                       pop,
   output fblpack_pkg::job_type       head_job,
   output fblpack_pkg::q_status_type  q_status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   fblpack_pkg::job_type slots [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == FullCnt);
   assign q_status.empty = (count_ff == '0);
   assign head_job       = slots[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store jobs
   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_job;
      end
   end

   // Never overrun or underrun
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !q_status.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

FILE: rtl/fblpack_back.sv
// ----------------------------------------------------------------------------
// fblpack_back
// Takes jobs from the queue and sends their bytes out one beat at a time
// through the output register.
// ----------------------------------------------------------------------------
module fblpack_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fblpack_pkg::q_status_type  q_status,
   input  fblpack_pkg::job_type       head_job,
   output logic                       pop,
   output logic                       rsp_valid,
   output fblpack_pkg::rsp_type       rsp_data,
   input  logic                       rsp_stall
);

   logic                 valid_ff, valid_in;
   fblpack_pkg::rsp_type data_ff, data_in;
   logic                 sel_ff, sel_in;

   logic out_free;
   logic load;

   // Load a new beat when the output register is empty or draining
   assign out_free = !valid_ff || !rsp_stall;
   assign load     = out_free && !q_status.empty;
   assign pop      = load && (sel_ff || !head_job.two);

   always_comb begin
      valid_in = out_free ? !q_status.empty : valid_ff;
      data_in  = data_ff;
      sel_in   = sel_ff;
      if (load) begin
         data_in = sel_ff ? head_job.second : head_job.first;
         sel_in  = !sel_ff && head_job.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // Second beat of a job is always a fifth-bit byte
   a_second_high: assert property (@(posedge clock) disable iff (reset)
      load && sel_ff |=> rsp_data.is_high_bits)
      else $error("second beat of job is not a fifth-bit byte");

endmodule

FILE: rtl/five_bit_letter_packer_core.sv
// ----------------------------------------------------------------------------
// five_bit_letter_packer_core
// Packs letters into 5-bit codes: nibble pair bytes plus one fifth-bit byte
// per group of eight, with a flush at the end of each message.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake             beat
//   req_     in   req_valid/req_stall   letter, end_of_message
//   rsp_     out  rsp_valid/rsp_stall   packed_byte, is_high_bits, last_byte
//
// One letter is taken per cycle while the job queue is not full; each letter yields zero, one or two bytes.
// The output register sends one byte per cycle while rsp_stall is low, so a
// letter that yields two bytes holds the back end for both of them; the job queue absorbs this.
// The first byte of a letter passes through a job queue slot and then the
// output register before it is on rsp_.
// Reset is synchronous and clears group state, queue and output valid.
// req_stall rises only when the job queue is full.
// ----------------------------------------------------------------------------
module five_bit_letter_packer_core #(
   parameter int QueueDepth = fblpack_pkg::QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  fblpack_pkg::req_type  req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output fblpack_pkg::rsp_type  rsp_data,
   input  logic                  rsp_stall
);

   fblpack_pkg::q_status_type q_status;
   fblpack_pkg::job_type      push_job;
   fblpack_pkg::job_type      head_job;
   logic                      push;
   logic                      pop;

   fblpack_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   fblpack_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   fblpack_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
